// ----- rtl/core/apke_pkg.sv -----
// shared types, constants and helper functions of the allele pair key encoder
`default_nettype none

package apke_pkg;

  // item kinds carried on tuser
  localparam logic [1:0] KIND_REF = 2'd0;
  localparam logic [1:0] KIND_ALT = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // hash constants
  localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2    = 32'h1b873593;
  localparam logic [31:0] MIX_ADD   = 32'he6546b64;
  localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;
  localparam logic [31:0] SEPARATOR = 32'h00000003;

  localparam logic [4:0] REV_MAX_LETTERS = 5'd11;
  localparam logic [4:0] PACK_TOP_SHIFT  = 5'd20;
  localparam logic [2:0] BLOCK_LETTERS   = 3'd6;
  localparam logic [3:0] COUNT_SAT       = 4'd12;

  // multiplier operations
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_K1   = 3'd1;
  localparam logic [2:0] MUL_K2   = 3'd2;
  localparam logic [2:0] MUL_F1   = 3'd3;
  localparam logic [2:0] MUL_F2   = 3'd4;

  // which mix is running
  localparam logic [1:0] MIX_BLK = 2'd0;
  localparam logic [1:0] MIX_SEP = 2'd1;
  localparam logic [1:0] MIX_ALT = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic [2:0] mul_op;
    logic [1:0] mix_sel;
    logic       mix_wr;
    logic       blk_clr;
    logic       set_alt;
    logic       take_letter;
    logic       emit_rev;
    logic       emit_hash;
    logic       clear_all;
  } apke_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       char_zero;
    logic       in_alt;
    logic       fill_nz;
    logic       fill_full;
    logic       rev_ok;
    logic       out_free;
  } apke_sts_t;

  // 2-bit base code, 4 for anything that is not a/c/g/t
  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] b;
    case (c) inside
      8'h41, 8'h61: b = 3'd0;
      8'h43, 8'h63: b = 3'd1;
      8'h47, 8'h67: b = 3'd2;
      8'h54, 8'h74: b = 3'd3;
      default:      b = 3'd4;
    endcase
    return b;
  endfunction

  // upper-cased letter minus 64, '*' as '[', wrapped to 32 bits
  function automatic logic [31:0] letter_value(input logic [7:0] c);
    logic [7:0] u;
    logic [8:0] d;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) u = c - 8'd32;
    if (u == 8'h2a) u = 8'h5b;
    d = {1'b0, u} - 9'd64;
    return {{23{d[8]}}, d};
  endfunction

  // slot position of a letter inside the block word
  function automatic logic [4:0] blk_shift(input logic [2:0] fill);
    logic [4:0] s;
    case (fill)
      3'd0:    s = 5'd26;
      3'd1:    s = 5'd21;
      3'd2:    s = 5'd16;
      3'd3:    s = 5'd11;
      3'd4:    s = 5'd6;
      default: s = 5'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/apke_ctrl.sv -----
// sequencing state machine of the allele pair key encoder
`default_nettype none

module apke_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire apke_pkg::apke_sts_t sts,
  output apke_pkg::apke_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_LETTER = 4'd2;
  localparam logic [3:0] S_LCHK   = 4'd3;
  localparam logic [3:0] S_MIX1   = 4'd4;
  localparam logic [3:0] S_MIX2   = 4'd5;
  localparam logic [3:0] S_MIX3   = 4'd6;
  localparam logic [3:0] S_FIN1   = 4'd7;
  localparam logic [3:0] S_FIN2   = 4'd8;
  localparam logic [3:0] S_FIN3   = 4'd9;
  localparam logic [3:0] S_REV    = 4'd10;

  // what follows a block mix
  localparam logic [1:0] CTX_SWITCH = 2'd0;
  localparam logic [1:0] CTX_FULL   = 2'd1;
  localparam logic [1:0] CTX_END    = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mix_sel_r, mix_sel_nxt;
  logic [1:0] ctx_r, ctx_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    mix_sel_nxt = mix_sel_r;
    ctx_nxt     = ctx_r;
    cmd         = '0;
    cmd.mix_sel = mix_sel_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_item = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.kind == apke_pkg::KIND_END) begin
          if (sts.rev_ok) begin
            state_nxt = S_REV;
          end else if (sts.fill_nz) begin
            mix_sel_nxt = apke_pkg::MIX_BLK;
            ctx_nxt     = CTX_END;
            state_nxt   = S_MIX1;
          end else begin
            mix_sel_nxt = apke_pkg::MIX_SEP;
            state_nxt   = S_MIX1;
          end
        end else if (!(sts.kind == apke_pkg::KIND_REF || sts.kind == apke_pkg::KIND_ALT) ||
                     sts.char_zero ||
                     (sts.kind == apke_pkg::KIND_REF && sts.in_alt)) begin
          state_nxt = S_IDLE;
        end else if (sts.kind == apke_pkg::KIND_ALT && !sts.in_alt) begin
          if (sts.fill_nz) begin
            mix_sel_nxt = apke_pkg::MIX_BLK;
            ctx_nxt     = CTX_SWITCH;
            state_nxt   = S_MIX1;
          end else begin
            cmd.set_alt = 1'b1;
            state_nxt   = S_LETTER;
          end
        end else begin
          state_nxt = S_LETTER;
        end
      end
      S_LETTER: begin
        cmd.take_letter = 1'b1;
        state_nxt       = S_LCHK;
      end
      S_LCHK: begin
        if (sts.fill_full) begin
          mix_sel_nxt = apke_pkg::MIX_BLK;
          ctx_nxt     = CTX_FULL;
          state_nxt   = S_MIX1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MIX1: begin
        cmd.mul_op = apke_pkg::MUL_K1;
        state_nxt  = S_MIX2;
      end
      S_MIX2: begin
        cmd.mul_op = apke_pkg::MUL_K2;
        state_nxt  = S_MIX3;
      end
      S_MIX3: begin
        cmd.mix_wr = 1'b1;
        case (mix_sel_r)
          apke_pkg::MIX_BLK: begin
            cmd.blk_clr = 1'b1;
            case (ctx_r)
              CTX_SWITCH: begin
                cmd.set_alt = 1'b1;
                state_nxt   = S_LETTER;
              end
              CTX_FULL: state_nxt = S_IDLE;
              default: begin
                mix_sel_nxt = apke_pkg::MIX_SEP;
                state_nxt   = S_MIX1;
              end
            endcase
          end
          apke_pkg::MIX_SEP: begin
            mix_sel_nxt = apke_pkg::MIX_ALT;
            state_nxt   = S_MIX1;
          end
          default: state_nxt = S_FIN1;
        endcase
      end
      S_FIN1: begin
        cmd.mul_op = apke_pkg::MUL_F1;
        state_nxt  = S_FIN2;
      end
      S_FIN2: begin
        cmd.mul_op = apke_pkg::MUL_F2;
        state_nxt  = S_FIN3;
      end
      S_FIN3: begin
        if (sts.out_free) begin
          cmd.emit_hash = 1'b1;
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REV: begin
        if (sts.out_free) begin
          cmd.emit_rev  = 1'b1;
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mix_sel_r <= apke_pkg::MIX_BLK;
      ctx_r     <= CTX_FULL;
    end else begin
      state_r   <= state_nxt;
      mix_sel_r <= mix_sel_nxt;
      ctx_r     <= ctx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/apke_dpath.sv -----
// datapath of the allele pair key encoder: accumulators, packer, multiplier, output register
`default_nettype none

module apke_dpath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire [1:0]           in_kind,
  input  wire [7:0]           in_char,
  input  wire apke_pkg::apke_cmd_t cmd,
  output apke_pkg::apke_sts_t sts,
  input  wire                 out_ready,
  output logic                out_valid,
  output logic [30:0]         out_code
);

  logic [1:0]  kind_r;
  logic [7:0]  char_r;
  logic [31:0] ref_acc_r, ref_acc_nxt;
  logic [31:0] alt_acc_r, alt_acc_nxt;
  logic [31:0] blk_r, blk_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [3:0]  ref_cnt_r, ref_cnt_nxt;
  logic [3:0]  alt_cnt_r, alt_cnt_nxt;
  logic [21:0] packed_r, packed_nxt;
  logic        acgt_r, acgt_nxt;
  logic        in_alt_r, in_alt_nxt;
  logic [31:0] mul_r, mul_nxt;
  logic [31:0] h_r, h_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_code_r, out_code_nxt;

  logic [4:0]  total;
  logic [2:0]  bcode;
  logic [4:0]  pack_sh;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] mix_h, mix_x, mix_rot, mix_res;
  logic [31:0] fin_x;

  assign total = {1'b0, ref_cnt_r} + {1'b0, alt_cnt_r};
  assign bcode = apke_pkg::base_code(char_r);
  assign pack_sh = apke_pkg::PACK_TOP_SHIFT - {total[3:0], 1'b0};

  // shared 32-bit multiplier, low half kept
  always_comb begin
    case (cmd.mul_op)
      apke_pkg::MUL_K1: begin
        case (cmd.mix_sel)
          apke_pkg::MIX_BLK: mul_a = blk_r;
          apke_pkg::MIX_SEP: mul_a = apke_pkg::SEPARATOR;
          default:           mul_a = alt_acc_r;
        endcase
        mul_b = apke_pkg::MIX_C1;
      end
      apke_pkg::MUL_K2: begin
        mul_a = {mul_r[16:0], mul_r[31:17]};
        mul_b = apke_pkg::MIX_C2;
      end
      apke_pkg::MUL_F1: begin
        mul_a = h_r ^ (h_r >> 16);
        mul_b = apke_pkg::FIN_C1;
      end
      apke_pkg::MUL_F2: begin
        mul_a = mul_r ^ (mul_r >> 13);
        mul_b = apke_pkg::FIN_C2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // last step of a mix: xor, rotate by 13, times 5 plus constant
  always_comb begin
    case (cmd.mix_sel)
      apke_pkg::MIX_BLK: mix_h = in_alt_r ? alt_acc_r : ref_acc_r;
      apke_pkg::MIX_SEP: mix_h = ref_acc_r;
      default:           mix_h = h_r;
    endcase
  end

  assign mix_x   = mix_h ^ mul_r;
  assign mix_rot = {mix_x[18:0], mix_x[31:19]};
  assign mix_res = (mix_rot << 2) + mix_rot + apke_pkg::MIX_ADD;
  assign fin_x   = mul_r ^ (mul_r >> 16);

  always_comb begin
    ref_acc_nxt   = ref_acc_r;
    alt_acc_nxt   = alt_acc_r;
    blk_nxt       = blk_r;
    fill_nxt      = fill_r;
    ref_cnt_nxt   = ref_cnt_r;
    alt_cnt_nxt   = alt_cnt_r;
    packed_nxt    = packed_r;
    acgt_nxt      = acgt_r;
    in_alt_nxt    = in_alt_r;
    h_nxt         = h_r;
    out_code_nxt  = out_code_r;
    mul_nxt       = (cmd.mul_op != apke_pkg::MUL_NONE) ? prod : mul_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.take_letter) begin
      if (bcode[2]) begin
        acgt_nxt = 1'b0;
      end else if (total < apke_pkg::REV_MAX_LETTERS) begin
        packed_nxt = packed_r | (22'(bcode[1:0]) << pack_sh);
      end
      if (in_alt_r) begin
        if (alt_cnt_r < apke_pkg::COUNT_SAT) alt_cnt_nxt = alt_cnt_r + 4'd1;
      end else begin
        if (ref_cnt_r < apke_pkg::COUNT_SAT) ref_cnt_nxt = ref_cnt_r + 4'd1;
      end
      blk_nxt  = blk_r | (apke_pkg::letter_value(char_r) << apke_pkg::blk_shift(fill_r));
      fill_nxt = fill_r + 3'd1;
    end

    if (cmd.mix_wr) begin
      case (cmd.mix_sel)
        apke_pkg::MIX_BLK: begin
          if (in_alt_r) alt_acc_nxt = mix_res;
          else          ref_acc_nxt = mix_res;
        end
        default: h_nxt = mix_res;
      endcase
    end

    if (cmd.blk_clr) begin
      blk_nxt  = '0;
      fill_nxt = '0;
    end
    if (cmd.set_alt) in_alt_nxt = 1'b1;

    if (cmd.emit_rev) begin
      out_code_nxt  = {ref_cnt_r, alt_cnt_r, packed_r, 1'b0};
      out_valid_nxt = 1'b1;
    end
    if (cmd.emit_hash) begin
      out_code_nxt  = {fin_x[31:2], 1'b1};
      out_valid_nxt = 1'b1;
    end

    if (cmd.clear_all) begin
      ref_acc_nxt = '0;
      alt_acc_nxt = '0;
      blk_nxt     = '0;
      fill_nxt    = '0;
      ref_cnt_nxt = '0;
      alt_cnt_nxt = '0;
      packed_nxt  = '0;
      acgt_nxt    = 1'b1;
      in_alt_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_acc_r   <= '0;
      alt_acc_r   <= '0;
      blk_r       <= '0;
      fill_r      <= '0;
      ref_cnt_r   <= '0;
      alt_cnt_r   <= '0;
      packed_r    <= '0;
      acgt_r      <= 1'b1;
      in_alt_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ref_acc_r   <= ref_acc_nxt;
      alt_acc_r   <= alt_acc_nxt;
      blk_r       <= blk_nxt;
      fill_r      <= fill_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
      alt_cnt_r   <= alt_cnt_nxt;
      packed_r    <= packed_nxt;
      acgt_r      <= acgt_nxt;
      in_alt_r    <= in_alt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      char_r <= in_char;
    end
    mul_r      <= mul_nxt;
    h_r        <= h_nxt;
    out_code_r <= out_code_nxt;
  end

  assign sts.kind      = kind_r;
  assign sts.char_zero = (char_r == 8'd0);
  assign sts.in_alt    = in_alt_r;
  assign sts.fill_nz   = (fill_r != 3'd0);
  assign sts.fill_full = (fill_r == apke_pkg::BLOCK_LETTERS);
  assign sts.rev_ok    = acgt_r && (total <= apke_pkg::REV_MAX_LETTERS) && (total != 5'd0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;

endmodule

`default_nettype wire

// ----- rtl/core/allele_pair_key_encoder.sv -----
// allele pair key encoder: allele characters in, one 31-bit pair code out per end request
// input stream: one request per character; in_tuser is the kind (reference letter,
//   alternate letter, end of pair), in_tdata the ascii character
// output stream: one request per end, out_tdata[30:0] is the code; bit 0 clear marks a
//   reversible code (lengths plus 2-bit bases), bit 0 set a hashed code
// in_tready is high only while the sequencer is idle; each request is taken one at a time
// a letter passes the dispatch, letter and check states; a mix on the multiplier runs
//   when it fills a six-letter block or the first alt letter closes the reference block
// an end request reaches the output register through the REV state for a reversible
//   code, and for a hashed one through an optional block flush, two mixes and two
//   finalizer multiplies, all on the single shared 32-bit multiplier
// a new input request is taken while a code waits in the output register; only the next
//   end request holds in its last step until out_tready frees that register
// reset clears the sequencer, all accumulators and counters and drops out_tvalid
`default_nettype none

module allele_pair_key_encoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // base_char[7:0]
  input  wire  [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // refalt_code[30:0], zero pad [31]
);

  apke_pkg::apke_cmd_t cmd;
  apke_pkg::apke_sts_t sts;
  logic [30:0]         code;

  // state machine: decides what each request needs and steps the mixes
  apke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: letter packing, block word, accumulators, multiplier, output register
  apke_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_kind   (in_tuser),
    .in_char   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_code  (code)
  );

  assign out_tdata = {1'b0, code};

endmodule

`default_nettype wire

// ----- rtl/core/apke_checker.sv -----
// port-level checks of the allele pair key encoder, bound to the top level
`default_nettype none

module apke_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata
);

  // a waiting code is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // requests are taken one at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

  // reversible code carries between 1 and 11 letters
  a_rev_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      (({1'b0, out_tdata[30:27]} + {1'b0, out_tdata[26:23]}) <= 5'd11) &&
      (({1'b0, out_tdata[30:27]} + {1'b0, out_tdata[26:23]}) != 5'd0))
    else $error("reversible code with bad lengths");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[31])
    else $error("pad bit of out_tdata set");

endmodule

bind allele_pair_key_encoder apke_checker u_apke_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
